### rtl/core/gqg_pkg.sv
`timescale 1ns / 1ps

package gqg_pkg;

  localparam int GLYPH_COUNT = 95;
  localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

  localparam int UNIT_W  = 18;
  localparam int POS_W   = 19;
  localparam int U_W     = 17;
  localparam int PIX_W   = 8;
  localparam int START_W = 12;
  localparam int PROD_W  = START_W + UNIT_W;
  localparam int SPAN_W  = PIX_W + UNIT_W;
  localparam int WIDE_W  = 32;

  localparam logic [UNIT_W-1:0] X_UNIT_RESET = UNIT_W'(102);
  localparam logic [UNIT_W-1:0] Y_UNIT_RESET = UNIT_W'(182);

  localparam logic CFG_X_UNIT = 1'b0;
  localparam logic CFG_Y_UNIT = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CHAR  = 1'b1;

  localparam logic [PIX_W-1:0] CODE_SPACE = 8'd32;
  localparam logic [PIX_W-1:0] CODE_LAST  = 8'd126;

  localparam logic signed [WIDE_W-1:0] Q16_ONE = 32'sd65536;
  localparam logic signed [WIDE_W-1:0] POS_MIN = -32'sd262144;
  localparam logic signed [WIDE_W-1:0] POS_MAX = 32'sd262143;

  localparam logic [2:0] VERT_LAST = 3'd5;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SPACE = 2'd1,
    KIND_GLYPH = 2'd2
  } kind_t;

  typedef struct packed {
    logic [U_W-1:0]   u_left;
    logic [U_W-1:0]   u_right;
    logic [PIX_W-1:0] pixels;
  } glyph_t;

  typedef struct packed {
    pos_t           left;
    pos_t           right;
    pos_t           top;
    pos_t           bottom;
    logic [U_W-1:0] u_left;
    logic [U_W-1:0] u_right;
  } quad_t;

  typedef struct packed {
    kind_t                kind;
    logic                 first;
    logic [START_W-1:0]   start_x;
    logic [START_W-1:0]   start_y;
  } char_item_t;

  function automatic pos_t clamp_pos(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] c;
    begin
      if (v < POS_MIN) begin
        c = POS_MIN;
      end else if (v > POS_MAX) begin
        c = POS_MAX;
      end else begin
        c = v;
      end
      return c[POS_W-1:0];
    end
  endfunction

endpackage

### rtl/core/glyph_quad_generator_unit.sv
`timescale 1ns / 1ps

// Path: a glyph passes the stage 1 and stage 2 registers, then the quad register, then the output register.
// Output: a glyph emits its six vertices in turn on the single output register;
//   spaces, table writes and skipped codes produce no vertices and do not occupy the sequencer.
// Reset (rst, synchronous): pen and row cleared to zero, pipeline emptied, units reloaded
//   to 102 and 182. Glyph table entries stay undefined until written.
module glyph_quad_generator_unit
  import gqg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [UNIT_W-1:0]       cfg_data,

  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    command,
  input  logic                    first,
  input  logic [START_W-1:0]      start_x,
  input  logic [START_W-1:0]      start_y,
  input  logic [7:0]              char_code,
  input  logic [6:0]              glyph_index,
  input  logic [U_W-1:0]          glyph_left,
  input  logic [U_W-1:0]          glyph_right,
  input  logic [PIX_W-1:0]        glyph_width,

  output logic                    vert_valid,
  input  logic                    vert_stall,
  output logic signed [POS_W-1:0] vert_x,
  output logic signed [POS_W-1:0] vert_y,
  output logic [U_W-1:0]          tex_u,
  output logic                    tex_v,
  output logic                    last
);

  logic [UNIT_W-1:0] x_unit;
  logic [UNIT_W-1:0] y_unit;

  logic       accept;
  logic       take;
  logic [7:0] code_idx;
  logic [7:0] wr_idx;
  logic       is_space;
  logic       is_glyph;
  logic       wr_ok;

  char_item_t item;
  glyph_t     wr_glyph;
  glyph_t     rd_glyph;
  logic       quad_valid;
  logic       quad_ready;
  quad_t      quad;

  // Configuration: always ready; the user must write it only while the pipeline is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_unit <= X_UNIT_RESET;
      y_unit <= Y_UNIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_X_UNIT: x_unit <= cfg_data;
        CFG_Y_UNIT: y_unit <= cfg_data;
      endcase
    end
  end

  // Input transaction: stall back only when stage 1 cannot drain.
  assign item_stall = !take;
  assign accept     = item_valid && take;

  // Classify the character: the space only moves the pen, codes outside the
  // table emit nothing but still honor the pen load.
  assign code_idx = char_code - CODE_SPACE;
  assign is_space = (command == CMD_CHAR) && (char_code == CODE_SPACE);
  assign is_glyph = (command == CMD_CHAR) && (char_code > CODE_SPACE) &&
                    (char_code <= CODE_LAST) && (code_idx < 8'(GLYPH_COUNT));

  assign wr_idx = {1'b0, glyph_index};
  assign wr_ok  = (command == CMD_WRITE) && (wr_idx < 8'(GLYPH_COUNT));

  assign item.kind    = is_glyph ? KIND_GLYPH : (is_space ? KIND_SPACE : KIND_NONE);
  assign item.first   = (command == CMD_CHAR) && first;
  assign item.start_x = start_x;
  assign item.start_y = start_y;

  assign wr_glyph.u_left  = glyph_left;
  assign wr_glyph.u_right = glyph_right;
  assign wr_glyph.pixels  = glyph_width;

  // Glyph table: written and looked up at the transaction edge, so a write
  // is always visible to any later character without forwarding.
  gqg_glyph_mem u_mem (
    .clk     (clk),
    .wr_en   (accept && wr_ok),
    .wr_addr (wr_idx[GLYPH_IDX_W-1:0]),
    .wr_data (wr_glyph),
    .rd_en   (accept && is_glyph),
    .rd_addr (code_idx[GLYPH_IDX_W-1:0]),
    .rd_data (rd_glyph)
  );

  // Pen tracking: start conversion, glyph span, pen advance and quad edges.
  gqg_pen_unit u_pen (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .take       (take),
    .x_unit     (x_unit),
    .y_unit     (y_unit),
    .glyph      (rd_glyph),
    .quad_valid (quad_valid),
    .quad       (quad),
    .quad_ready (quad_ready)
  );

  // Vertex sequencer: walk the six corners into the output register.
  gqg_vertex_seq u_vert (
    .clk        (clk),
    .rst        (rst),
    .quad_valid (quad_valid),
    .quad_in    (quad),
    .quad_ready (quad_ready),
    .vert_valid (vert_valid),
    .vert_stall (vert_stall),
    .vert_x     (vert_x),
    .vert_y     (vert_y),
    .tex_u      (tex_u),
    .tex_v      (tex_v),
    .last       (last)
  );

endmodule

### rtl/core/gqg_glyph_mem.sv
`timescale 1ns / 1ps

module gqg_glyph_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [gqg_pkg::GLYPH_IDX_W-1:0] wr_addr,
  input  gqg_pkg::glyph_t               wr_data,
  input  logic                          rd_en,
  input  logic [gqg_pkg::GLYPH_IDX_W-1:0] rd_addr,
  output gqg_pkg::glyph_t               rd_data
);
  import gqg_pkg::*;

  glyph_t mem [GLYPH_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next lookup
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/gqg_pen_unit.sv
`timescale 1ns / 1ps

module gqg_pen_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  gqg_pkg::char_item_t             item,
  output logic                            take,
  input  logic [gqg_pkg::UNIT_W-1:0]      x_unit,
  input  logic [gqg_pkg::UNIT_W-1:0]      y_unit,
  input  gqg_pkg::glyph_t                 glyph,
  output logic                            quad_valid,
  output gqg_pkg::quad_t                  quad,
  input  logic                            quad_ready
);
  import gqg_pkg::*;

  // stage 1: raw start products, glyph entry arriving from memory
  logic              s1_valid;
  kind_t             s1_kind;
  logic              s1_first;
  logic [PROD_W-1:0] s1_px;
  logic [PROD_W-1:0] s1_py;

  // stage 2: converted start position and glyph span
  logic              s2_valid;
  kind_t             s2_kind;
  logic              s2_first;
  pos_t              s2_loadx;
  pos_t              s2_loady;
  logic [SPAN_W-1:0] s2_span;
  logic [U_W-1:0]    s2_u_left;
  logic [U_W-1:0]    s2_u_right;

  pos_t pen_x;
  pos_t row_top;

  logic s1_adv;
  logic s2_adv;
  logic s2_take;

  pos_t                     pen_base;
  pos_t                     top_base;
  logic signed [WIDE_W-1:0] pen_wide;
  logic signed [WIDE_W-1:0] top_wide;
  logic signed [WIDE_W-1:0] span_wide;
  logic signed [WIDE_W-1:0] xu_wide;
  logic signed [WIDE_W-1:0] xu3_wide;
  logic signed [WIDE_W-1:0] yu16_wide;
  pos_t                     pen_x_next;

  assign s2_adv  = s2_valid && ((s2_kind != KIND_GLYPH) || quad_ready);
  assign s2_take = !s2_valid || s2_adv;
  assign s1_adv  = s1_valid && s2_take;
  assign take    = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind  <= item.kind;
      s1_first <= item.first;
      s1_px    <= item.start_x * x_unit;
      s1_py    <= item.start_y * y_unit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_take) begin
      s2_valid <= s1_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_kind    <= s1_kind;
      s2_first   <= s1_first;
      s2_loadx   <= clamp_pos($signed({2'b00, s1_px}) - Q16_ONE);
      s2_loady   <= clamp_pos(Q16_ONE - $signed({2'b00, s1_py}));
      s2_span    <= glyph.pixels * x_unit;
      s2_u_left  <= glyph.u_left;
      s2_u_right <= glyph.u_right;
    end
  end

  assign pen_base  = s2_first ? s2_loadx : pen_x;
  assign top_base  = s2_first ? s2_loady : row_top;
  assign pen_wide  = WIDE_W'(pen_base);
  assign top_wide  = WIDE_W'(top_base);
  assign span_wide = $signed({{(WIDE_W - SPAN_W){1'b0}}, s2_span});
  assign xu_wide   = $signed({{(WIDE_W - UNIT_W){1'b0}}, x_unit});
  assign xu3_wide  = xu_wide + (xu_wide <<< 1);
  assign yu16_wide = $signed({{(WIDE_W - UNIT_W){1'b0}}, y_unit}) <<< 4;

  always_comb begin
    unique case (s2_kind)
      KIND_SPACE: pen_x_next = clamp_pos(pen_wide + xu3_wide);
      KIND_GLYPH: pen_x_next = clamp_pos(pen_wide + span_wide + xu_wide);
      default:    pen_x_next = pen_base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x   <= '0;
      row_top <= '0;
    end else if (s2_adv) begin
      pen_x   <= pen_x_next;
      row_top <= top_base;
    end
  end

  assign quad_valid     = s2_valid && (s2_kind == KIND_GLYPH);
  assign quad.left      = pen_base;
  assign quad.right     = clamp_pos(pen_wide + span_wide);
  assign quad.top       = top_base;
  assign quad.bottom    = clamp_pos(top_wide - yu16_wide);
  assign quad.u_left    = s2_u_left;
  assign quad.u_right   = s2_u_right;

endmodule

### rtl/core/gqg_vertex_seq.sv
`timescale 1ns / 1ps

module gqg_vertex_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        quad_valid,
  input  gqg_pkg::quad_t              quad_in,
  output logic                        quad_ready,
  output logic                        vert_valid,
  input  logic                        vert_stall,
  output logic signed [gqg_pkg::POS_W-1:0] vert_x,
  output logic signed [gqg_pkg::POS_W-1:0] vert_y,
  output logic [gqg_pkg::U_W-1:0]     tex_u,
  output logic                        tex_v,
  output logic                        last
);
  import gqg_pkg::*;

  logic       busy;
  quad_t      q;
  logic [2:0] cnt;
  logic       load;
  logic       done;

  pos_t           x_sel;
  pos_t           y_sel;
  logic [U_W-1:0] u_sel;
  logic           v_sel;

  assign load       = busy && (!vert_valid || !vert_stall);
  assign done       = load && (cnt == VERT_LAST);
  assign quad_ready = !busy || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (quad_ready) begin
      busy <= quad_valid;
      cnt  <= '0;
    end else if (load) begin
      cnt <= cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_ready && quad_valid) begin
      q <= quad_in;
    end
  end

  // two triangles: TL BR BL, TL TR BR
  always_comb begin
    unique case (cnt)
      3'd0, 3'd3: begin
        x_sel = q.left;  y_sel = q.top;    u_sel = q.u_left;  v_sel = 1'b0;
      end
      3'd1, 3'd5: begin
        x_sel = q.right; y_sel = q.bottom; u_sel = q.u_right; v_sel = 1'b1;
      end
      3'd2: begin
        x_sel = q.left;  y_sel = q.bottom; u_sel = q.u_left;  v_sel = 1'b1;
      end
      3'd4: begin
        x_sel = q.right; y_sel = q.top;    u_sel = q.u_right; v_sel = 1'b0;
      end
      default: begin
        x_sel = q.left;  y_sel = q.top;    u_sel = q.u_left;  v_sel = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vert_valid <= 1'b0;
    end else if (load) begin
      vert_valid <= 1'b1;
    end else if (!vert_stall) begin
      vert_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vert_x <= x_sel;
      vert_y <= y_sel;
      tex_u  <= u_sel;
      tex_v  <= v_sel;
      last   <= (cnt == VERT_LAST);
    end
  end

endmodule
